FILE: rtl/pxs_pkg.sv
`timescale 1ns / 1ps

package pxs_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic load;
    logic bwd_rd;
    logic bwd_mul;
    logic bwd_wr;
    logic fwd_rd;
    logic fwd_take;
  } cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic at_end;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/pxs_ram.sv
`timescale 1ns / 1ps

module pxs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/pxs_dp.sv
`timescale 1ns / 1ps

module pxs_dp import pxs_pkg::*; #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [DATA_W-1:0] value_i,
  input  logic              is_last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] product_o,
  output logic              end_of_run_o
);

  localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] rp_q, rp_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  last_idx_q, last_idx_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] suffix_q, suffix_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [IDX_W-1:0]  wr_idx_q, wr_idx_d;
  logic [DATA_W-1:0] out_product_q, out_product_d;
  logic              out_end_q, out_end_d;

  logic              store_ok;
  logic [IDX_W-1:0]  count_idx;
  logic [DATA_W-1:0] rp_prod, res_prod, suffix_prod;
  logic              elem_we;
  logic              pfx_we;
  logic [IDX_W-1:0]  pfx_waddr;
  logic [DATA_W-1:0] pfx_wdata;
  logic [DATA_W-1:0] elem_rdata;
  logic [DATA_W-1:0] pfx_rdata;

  assign store_ok  = count_q < CNT_W'(MAX_LEN);
  assign count_idx = count_q[IDX_W-1:0];

  assign rp_prod     = rp_q * value_i;
  assign res_prod    = pfx_rdata * suffix_q;
  assign suffix_prod = suffix_q * elem_rdata;

  // element store written only while loading, prefix store reused for results
  assign elem_we   = cmd_i.load && store_ok;
  assign pfx_we    = elem_we || ((cmd_i.bwd_rd || cmd_i.bwd_wr) && pend_q);
  assign pfx_waddr = cmd_i.load ? count_idx : wr_idx_q;
  assign pfx_wdata = cmd_i.load ? rp_q : res_q;

  pxs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_LEN)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (count_idx),
    .wdata_i (value_i),
    .raddr_i (idx_q),
    .rdata_o (elem_rdata)
  );

  pxs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_LEN)
  ) u_pfx_ram (
    .clk_i   (clk_i),
    .we_i    (pfx_we),
    .waddr_i (pfx_waddr),
    .wdata_i (pfx_wdata),
    .raddr_i (idx_q),
    .rdata_o (pfx_rdata)
  );

  always_comb begin
    count_d       = count_q;
    rp_d          = rp_q;
    idx_d         = idx_q;
    last_idx_d    = last_idx_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q;
    suffix_d      = suffix_q;
    res_d         = res_q;
    wr_idx_d      = wr_idx_q;
    out_product_d = out_product_q;
    out_end_d     = out_end_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      if (store_ok) begin
        rp_d    = rp_prod;
        count_d = count_q + CNT_W'(1);
      end
      if (is_last_i) begin
        idx_d      = store_ok ? count_idx : IDX_W'(MAX_LEN - 1);
        last_idx_d = idx_d;
        count_d    = '0;
        rp_d       = DATA_W'(1);
        suffix_d   = DATA_W'(1);
        pend_d     = 1'b0;
      end
    end

    if (cmd_i.bwd_rd || cmd_i.bwd_wr) begin
      pend_d = 1'b0;
    end

    if (cmd_i.bwd_mul) begin
      res_d    = res_prod;
      suffix_d = suffix_prod;
      wr_idx_d = idx_q;
      pend_d   = 1'b1;
      if (idx_q != '0) begin
        idx_d = idx_q - IDX_W'(1);
      end
    end

    if (cmd_i.fwd_take) begin
      out_valid_d   = 1'b1;
      out_product_d = pfx_rdata;
      out_end_d     = sts_o.at_end;
      if (!sts_o.at_end) begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rp_q        <= DATA_W'(1);
      idx_q       <= '0;
      last_idx_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rp_q        <= rp_d;
      idx_q       <= idx_d;
      last_idx_q  <= last_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    suffix_q      <= suffix_d;
    res_q         <= res_d;
    wr_idx_q      <= wr_idx_d;
    out_product_q <= out_product_d;
    out_end_q     <= out_end_d;
  end

  assign sts_o.idx_zero = idx_q == '0;
  assign sts_o.at_end   = idx_q == last_idx_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign product_o    = out_product_q;
  assign end_of_run_o = out_end_q;

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && is_last_i |=> count_q == '0 && rp_q == DATA_W'(1))
    else $error("state not rearmed after last word");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load |-> idx_q <= last_idx_q)
    else $error("index beyond last position");

  a_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fwd_rd |-> !pend_q)
    else $error("result write still pending at forward read");

endmodule

FILE: rtl/pxs_ctrl.sv
`timescale 1ns / 1ps

module pxs_ctrl import pxs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic is_last_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_BRD  = 6'b000010,
    ST_BMUL = 6'b000100,
    ST_BWR  = 6'b001000,
    ST_FRD  = 6'b010000,
    ST_FOUT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && is_last_i) begin
          state_d = ST_BRD;
        end
      end
      ST_BRD:  state_d = ST_BMUL;
      ST_BMUL: state_d = sts_i.idx_zero ? ST_BWR : ST_BRD;
      ST_BWR:  state_d = ST_FRD;
      ST_FRD:  state_d = ST_FOUT;
      ST_FOUT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.at_end ? ST_LOAD : ST_FRD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o     = state_q != ST_LOAD;
  assign cmd_o.load     = (state_q == ST_LOAD) && in_valid_i;
  assign cmd_o.bwd_rd   = state_q == ST_BRD;
  assign cmd_o.bwd_mul  = state_q == ST_BMUL;
  assign cmd_o.bwd_wr   = state_q == ST_BWR;
  assign cmd_o.fwd_rd   = state_q == ST_FRD;
  assign cmd_o.fwd_take = (state_q == ST_FOUT) && sts_i.out_free;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BWR |=> state_q == ST_FRD)
    else $error("backward walk not followed by forward read");

  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fwd_take && sts_i.at_end |=> state_q == ST_LOAD && !in_stall_o)
    else $error("no return to loading after final word");

endmodule

FILE: rtl/product_except_self.sv
`timescale 1ns / 1ps

// Product of all other elements. Words of a vector arrive one per cycle
// while in_stall_o is low, is_last_i on the final one; up to MAX_LEN are
// kept, later ones dropped (a dropped word with is_last_i still ends the
// vector). After the last word the input stalls: a backward walk over the
// element and prefix memories reads and multiplies each element in turn and
// writes the results into the prefix memory, then results come out in
// original order, one memory read per word, end_of_run_o on the last; the
// next vector is taken only after the last result is issued. All products
// wrap to 32 bits; a one-element vector gives 1.
module product_except_self import pxs_pkg::*; #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     is_last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] product_o,
  output logic                     end_of_run_o
);

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] product;

  pxs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .is_last_i  (is_last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pxs_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      ($unsigned(value_i)),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .product_o    (product),
    .end_of_run_o (end_of_run_o)
  );

  assign product_o = $signed(product);

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb import pxs_pkg::*;;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    logic              end_of_run;
  } result_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value = '0;
  logic                     is_last = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] product;
  logic                     end_of_run;

  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  int unsigned words_sent = 0;
  int unsigned fail_count = 0;

  // predictor state
  logic [DATA_W-1:0] elem_mem [MAX_LEN];
  logic [DATA_W-1:0] prefix_mem [MAX_LEN];
  logic [DATA_W-1:0] prefix_acc = 1;
  int unsigned       elem_cnt = 0;
  result_word_t      pending_products [$];

  product_except_self #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value),
    .is_last_i   (is_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .product_o   (product),
    .end_of_run_o(end_of_run)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic predict_products(input logic [DATA_W-1:0] v, input logic last);
    logic [DATA_W-1:0] suffix;
    result_word_t      row [MAX_LEN];
    int                n;
    if (elem_cnt < MAX_LEN) begin
      elem_mem[elem_cnt] = v;
      prefix_mem[elem_cnt] = prefix_acc;
      prefix_acc = prefix_acc * v;
      elem_cnt++;
    end
    if (last) begin
      n = elem_cnt;
      suffix = 1;
      for (int i = n - 1; i >= 0; i--) begin
        row[i].product = prefix_mem[i] * suffix;
        row[i].end_of_run = (i == n - 1);
        suffix = suffix * elem_mem[i];
      end
      for (int i = 0; i < n; i++) pending_products = {pending_products, row[i]};
      elem_cnt = 0;
      prefix_acc = 1;
    end
  endtask

  // entered just after a rising edge; leaves valid high after acceptance
  task automatic send_word(input logic [DATA_W-1:0] v, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    value <= v;
    is_last <= last;
    do @(posedge clk); while (in_stall);
    predict_products(v, last);
    words_sent++;
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(1);
      4: return $urandom_range(15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_vector(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_word(rand_value(), i == len - 1);
  endtask

  task automatic test_single_element();
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7fff_ffff, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hffff_ffff, 1'b1);
  endtask

  task automatic test_extreme_values();
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0000_0003, 1'b1);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);
  endtask

  task automatic test_zero_elements();
    send_word(32'h0000_0007, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_fffb, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b1);
  endtask

  // words past MAX_LEN are dropped, the dropped last word still closes the vector
  task automatic test_overlong_vector();
    send_random_vector(MAX_LEN + 2);
  endtask

  task automatic test_random_vectors(input int unsigned target_words);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    start = words_sent;
    while (words_sent - start < target_words) begin
      r = $urandom_range(99);
      if (r < 75) len = $urandom_range(8, 1);
      else if (r < 93) len = $urandom_range(24, 9);
      else if (r < 97) len = MAX_LEN;
      else len = $urandom_range(MAX_LEN + 3, MAX_LEN + 1);
      send_random_vector(len);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < dst_idle_pct);
    end
  end

  initial begin
    result_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_products.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected word: product %0d end_of_run %0b", product, end_of_run);
        end else begin
          want = pending_products.pop_front();
          if (product !== want.product || end_of_run !== want.end_of_run) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: product exp %0d got %0d, end_of_run exp %0b got %0b",
                       $signed(want.product), product, want.end_of_run, end_of_run);
          end
        end
      end
    end
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 11;
    dst_idle_pct = 68;
    test_single_element();
    test_extreme_values();
    test_zero_elements();
    test_random_vectors(85);

    src_idle_pct = 68;
    dst_idle_pct = 11;
    test_overlong_vector();
    test_random_vectors(85);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_random_vectors(85);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
